@@ design/ncdf_pkg.sv @@
// shared types and constants for the normalized cdf builder
package ncdf_pkg;

  localparam int unsigned WeightW   = 32;
  localparam int unsigned TotalW    = 38;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned CdfW      = 17;
  localparam int unsigned CountW    = 7;
  localparam int unsigned FracW     = 16;
  localparam int unsigned DividendW = TotalW + FracW + 1;
  localparam int unsigned OutDataW  = 32;

  localparam logic [CdfW-1:0] OneQ16 = CdfW'(1) << FracW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_SETUP,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

@@ design/ncdf_div.sv @@
// restoring divider, one quotient bit per cycle, 17-bit quotient
module ncdf_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [ncdf_pkg::DividendW-1:0]        dividend_i,
  input  logic [ncdf_pkg::TotalW-1:0]           divisor_i,
  output logic                                  done_o,
  output logic [ncdf_pkg::CdfW-1:0]             quotient_o
);

  localparam int unsigned QW    = ncdf_pkg::CdfW;
  localparam int unsigned RW    = ncdf_pkg::TotalW;
  localparam int unsigned StepW = $clog2(QW);

  logic [RW-1:0]    rem_q;
  logic [RW-1:0]    div_q;
  logic [QW-1:0]    dq_q;
  logic [QW-1:0]    q_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;

  logic [RW:0]      rem_shift;
  logic [RW:0]      rem_diff;
  logic             take;
  logic             last_step;

  assign rem_shift = {rem_q, dq_q[QW-1]};
  assign take      = rem_shift >= {1'b0, div_q};
  assign rem_diff  = rem_shift - {1'b0, div_q};
  assign last_step = step_q == StepW'(QW - 1);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath; upper dividend bits are always below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[ncdf_pkg::DividendW-1:QW];
      dq_q  <= dividend_i[QW-1:0];
      div_q <= divisor_i;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= take ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
      dq_q  <= {dq_q[QW-2:0], 1'b0};
      q_q   <= {q_q[QW-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule

@@ design/normalized_cdf_builder.sv @@
// normalized cdf builder top level: prefix-sum store, emission sequencer, output register
//
// Loads one emitter weight per transfer on the slave stream (flux or area, picked by
// the cfg register; negative weights count as zero) and keeps a running Q22.16 prefix
// sum per entry in a synchronous RAM; tready stays high while loading. The transfer
// with tlast closes the set: the block then stops accepting input and emits one result
// per loaded entry, in index order, with cdf = round(prefix * 65536 / total) in Q1.16.
// If the total weight is zero the uniform value floor((i+1) * 65536 / count) is used
// and tuser is raised. The final entry is always exactly 65536 and carries tlast.
// Each non-final entry passes through a RAM read, a setup state that starts the
// divider, the bit-serial divider (17 quotient bits, then a registered done) and
// the load into the output register, which waits while that register is full and
// the sink holds tready low; the final entry skips the divider. Loading of the
// next set starts as soon as the final entry sits in the output register. Weights
// beyond MAX_ENTRIES are dropped, but their tlast still closes the set. The store
// needs no clearing after reset.
module normalized_cdf_builder #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // use_flux_weight
  // weight stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] flux_weight, [63:32] area_weight
  input  logic        s_axis_tlast,   // last_item
  // cdf stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] entry_index, [22:6] cdf_value,
                                      // [29:23] entry_count, [31:30] zero
  output logic        m_axis_tuser,   // uniform_fallback
  output logic        m_axis_tlast    // last_entry
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW   = ncdf_pkg::TotalW;
  localparam int unsigned WW   = ncdf_pkg::WeightW;
  localparam int unsigned DW   = ncdf_pkg::DividendW;

  // config register
  logic use_flux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_flux_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      use_flux_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // state
  ncdf_pkg::state_e state_q, state_d;

  logic [TW-1:0]   total_q;
  logic [CntW-1:0] count_q;
  logic [TW-1:0]   emit_total_q;
  logic [CntW-1:0] emit_count_q;
  logic            uniform_q;
  logic [IdxW-1:0] idx_q;
  logic [ncdf_pkg::CdfW-1:0] res_q;

  // prefix-sum ram, read data registered
  logic [TW-1:0] prefix_mem [MAX_ENTRIES];
  logic [TW-1:0] rd_data_q;

  // output register
  logic                        out_valid_q;
  logic [ncdf_pkg::IndexW-1:0] out_index_q;
  logic [ncdf_pkg::CdfW-1:0]   out_cdf_q;
  logic [ncdf_pkg::CountW-1:0] out_count_q;
  logic                        out_uniform_q;
  logic                        out_last_q;

  // fsm outputs
  logic in_ready;
  logic rd_en;
  logic div_start;
  logic out_load;

  // divider
  logic                      div_done;
  logic [ncdf_pkg::CdfW-1:0] div_quot;
  logic [DW-1:0]             div_dividend;
  logic [TW-1:0]             div_divisor;

  // load path: clamp negative weight, add into running total
  logic [WW-1:0]   weight_raw;
  logic [TW-1:0]   weight;
  logic [TW-1:0]   total_sum;
  logic            has_room;
  logic            in_fire;
  logic [TW-1:0]   total_next;
  logic [CntW-1:0] count_next;

  assign weight_raw = use_flux_q ? s_axis_tdata[WW-1:0] : s_axis_tdata[2*WW-1:WW];
  assign weight     = weight_raw[WW-1] ? '0 : TW'(weight_raw);
  assign total_sum  = total_q + weight;
  assign has_room   = count_q < CntW'(MAX_ENTRIES);
  assign in_fire    = s_axis_tvalid && in_ready;
  assign total_next = has_room ? total_sum : total_q;
  assign count_next = has_room ? count_q + CntW'(1) : count_q;

  // emission helpers
  logic [CntW-1:0] idx_plus1;
  logic            idx_is_last;
  logic            out_free;

  assign idx_plus1   = CntW'(idx_q) + CntW'(1);
  assign idx_is_last = idx_plus1 == emit_count_q;
  assign out_free    = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ncdf_pkg::ST_LOAD: begin
        if (in_fire && s_axis_tlast) begin
          state_d = ncdf_pkg::ST_READ;
        end
      end
      ncdf_pkg::ST_READ:  state_d = ncdf_pkg::ST_SETUP;
      ncdf_pkg::ST_SETUP: state_d = idx_is_last ? ncdf_pkg::ST_OUT : ncdf_pkg::ST_DIV;
      ncdf_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = ncdf_pkg::ST_OUT;
        end
      end
      ncdf_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = idx_is_last ? ncdf_pkg::ST_LOAD : ncdf_pkg::ST_READ;
        end
      end
      default: state_d = ncdf_pkg::ST_LOAD;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ncdf_pkg::ST_LOAD:  in_ready  = 1'b1;
      ncdf_pkg::ST_READ:  rd_en     = 1'b1;
      ncdf_pkg::ST_SETUP: div_start = !idx_is_last;
      ncdf_pkg::ST_OUT:   out_load  = out_free;
      default: ;
    endcase
  end

  assign s_axis_tready = in_ready;

  // divider operands: rounded prefix/total, or uniform (i+1)/count
  assign div_dividend = uniform_q
                      ? DW'({idx_plus1, ncdf_pkg::FracW'(0)})
                      : DW'({rd_data_q, ncdf_pkg::FracW'(0)}) + DW'(emit_total_q >> 1);
  assign div_divisor  = uniform_q ? TW'(emit_count_q) : emit_total_q;

  ncdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ram write on each stored weight, read one entry per emitted result
  always_ff @(posedge clk_i) begin
    if (in_fire && has_room) begin
      prefix_mem[count_q[IdxW-1:0]] <= total_sum;
    end
    if (rd_en) begin
      rd_data_q <= prefix_mem[idx_q];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncdf_pkg::ST_LOAD;
      total_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        // set closes on tlast: running state starts over
        total_q <= s_axis_tlast ? '0 : total_next;
        count_q <= s_axis_tlast ? '0 : count_next;
        idx_q   <= '0;
      end else if (out_load && !idx_is_last) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // per-set snapshot and result holding
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      emit_total_q <= total_next;
      emit_count_q <= count_next;
      uniform_q    <= total_next == '0;
    end
    if (state_q == ncdf_pkg::ST_SETUP && idx_is_last) begin
      res_q <= ncdf_pkg::OneQ16;
    end else if (state_q == ncdf_pkg::ST_DIV && div_done) begin
      res_q <= div_quot;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q   <= ncdf_pkg::IndexW'(idx_q);
      out_cdf_q     <= res_q;
      out_count_q   <= ncdf_pkg::CountW'(emit_count_q);
      out_uniform_q <= uniform_q;
      out_last_q    <= idx_is_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ncdf_pkg::OutDataW'({out_count_q, out_cdf_q, out_index_q});
  assign m_axis_tuser  = out_uniform_q;
  assign m_axis_tlast  = out_last_q;

endmodule
